// ----- rtl/tcws_pkg.sv -----
// Shared types and constants for the three-channel window statistics core.
package tcws_pkg;

	localparam int CHANNELS   = 3;
	localparam int CH_W       = 2;
	localparam int ADC_W      = 12;
	localparam int SAMPLE_W   = CHANNELS * ADC_W;
	localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
	localparam int PCT_W      = 14;
	localparam int OUT_FIELDS = CHANNELS * 3;
	localparam int OUT_DATA_W = ((OUT_FIELDS * PCT_W + 7) / 8) * 8;

	localparam int WINDOW_LEN = 60;
	localparam int WALK_CNT_W = $clog2(WINDOW_LEN);
	localparam int FULL_SCALE = 4095;
	localparam int PCT_SCALE  = 10000;
	localparam int SUM_W      = $clog2(WINDOW_LEN * FULL_SCALE + 1);

	// mean = round(sum * 10000 / (60 * 4095)); common factor 100 taken out
	localparam int MEAN_DIV    = 100;
	localparam int MEAN_MUL    = PCT_SCALE / MEAN_DIV;
	localparam int MEAN_DEN    = WINDOW_LEN * FULL_SCALE / MEAN_DIV;
	localparam int MEAN_BIAS   = MEAN_DEN / 2;
	localparam int MINMAX_BIAS = FULL_SCALE / 2;

	// scaled numerator before the constant divide, wide enough for both kinds
	localparam int X_W         = 26;
	// floor(x / d) == (x * ceil(2^38 / d)) >> 38 for every x below 2^X_W
	localparam int RECIP_SHIFT = 38;
	localparam int RECIP_W     = 27;
	localparam int PROD_W      = X_W + RECIP_W;
	localparam logic [RECIP_W-1:0] MINMAX_RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + FULL_SCALE - 1) / FULL_SCALE);
	localparam logic [RECIP_W-1:0] MEAN_RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + MEAN_DEN - 1) / MEAN_DEN);

	localparam logic FUNC_STORE  = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	typedef enum logic [1:0] {
		KIND_MEAN,
		KIND_MIN,
		KIND_MAX
	} stat_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_CONV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             store_en;
		logic             walk_start;
		logic             rd_en;
		logic             conv_en;
		stat_kind_t       conv_kind;
		logic [CH_W-1:0]  conv_ch;
		logic             load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} dp_stat_t;

endpackage

// ----- rtl/tcws_ctrl.sv -----
// Controller state machine: sequences store, window walk and percent conversion.
module tcws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_func,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output tcws_pkg::dp_cmd_t cmd,
	input  tcws_pkg::dp_stat_t stat
);
	import tcws_pkg::*;

	state_t                  state_q, state_d;
	logic [WALK_CNT_W-1:0]   walk_cnt_q;
	logic [CH_W-1:0]         ch_q;
	stat_kind_t              kind_q;
	logic                    out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.conv_ch   = ch_q;
		cmd.conv_kind = kind_q;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_func == FUNC_REPORT) begin
						cmd.walk_start = 1'b1;
						state_d        = ST_WALK;
					end else begin
						cmd.store_en = 1'b1;
					end
				end
			end
			ST_WALK: begin
				cmd.rd_en = 1'b1;
				if (walk_cnt_q == WALK_CNT_W'(WINDOW_LEN - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_en = 1'b1;
				if (ch_q == CH_LAST && kind_q == KIND_MAX) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!stat.pipe_busy && (!out_valid_q || out_ready)) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_cnt_q  <= '0;
			ch_q        <= '0;
			kind_q      <= KIND_MEAN;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.walk_start) begin
				walk_cnt_q <= '0;
			end else if (cmd.rd_en) begin
				walk_cnt_q <= walk_cnt_q + 1'b1;
			end

			if (cmd.walk_start) begin
				ch_q   <= '0;
				kind_q <= KIND_MEAN;
			end else if (cmd.conv_en) begin
				case (kind_q)
					KIND_MEAN: kind_q <= KIND_MIN;
					KIND_MIN:  kind_q <= KIND_MAX;
					default: begin
						kind_q <= KIND_MEAN;
						ch_q   <= ch_q + 1'b1;
					end
				endcase
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/tcws_dp.sv -----
// Datapath: sample ring, window accumulators, percent conversion and result register.
module tcws_dp #(
	parameter int RING_DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tcws_pkg::dp_cmd_t               cmd,
	output tcws_pkg::dp_stat_t              stat,
	input  logic [tcws_pkg::IN_DATA_W-1:0]  in_data,
	output logic [tcws_pkg::OUT_DATA_W-1:0] out_data
);
	import tcws_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

	logic [SAMPLE_W-1:0] ring [RING_DEPTH];

	logic [PTR_W-1:0]    wp_q, rp_q;
	logic                wrapped_q;
	logic                rd_vld_s1, ok_s1;
	logic [SAMPLE_W-1:0] rd_data_s1;

	logic [SUM_W-1:0]    sum_q [CHANNELS];
	logic [ADC_W-1:0]    lo_q  [CHANNELS];
	logic [ADC_W-1:0]    hi_q  [CHANNELS];
	logic [ADC_W-1:0]    v     [CHANNELS];

	logic [X_W-1:0]      x_d, x_s1;
	logic                conv_vld_s1, conv_vld_s2;
	stat_kind_t          kind_s1, kind_s2;
	logic [CH_W-1:0]     ch_s1, ch_s2;
	logic [RECIP_W-1:0]  recip;
	logic [PROD_W-1:0]   p_s2;
	logic [PCT_W-1:0]    res_q [CHANNELS][3];
	logic [OUT_DATA_W-1:0] packed_res, out_data_q;

	// ring store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.store_en) begin
			ring[wp_q] <= in_data[SAMPLE_W-1:0];
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= ring[rp_q];
		end
	end

	// entries at or past wp before the first wrap were never written: read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			wrapped_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			ok_s1     <= 1'b0;
		end else begin
			if (cmd.store_en) begin
				wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
				if (wp_q == LAST_IDX) begin
					wrapped_q <= 1'b1;
				end
			end
			if (cmd.walk_start) begin
				rp_q <= (wp_q == '0) ? LAST_IDX : wp_q - 1'b1;
			end else if (cmd.rd_en) begin
				rp_q <= (rp_q == '0) ? LAST_IDX : rp_q - 1'b1;
			end
			rd_vld_s1 <= cmd.rd_en;
			ok_s1     <= wrapped_q || (rp_q < wp_q);
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			v[c] = ok_s1 ? rd_data_s1[c*ADC_W +: ADC_W] : '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++) begin
			if (cmd.walk_start) begin
				sum_q[c] <= '0;
				lo_q[c]  <= ADC_W'(FULL_SCALE);
				hi_q[c]  <= '0;
			end else if (rd_vld_s1) begin
				sum_q[c] <= sum_q[c] + SUM_W'(v[c]);
				if (v[c] < lo_q[c]) begin
					lo_q[c] <= v[c];
				end
				if (v[c] > hi_q[c]) begin
					hi_q[c] <= v[c];
				end
			end
		end
	end

	// conversion stage 1: scale and add rounding bias
	always_comb begin
		case (cmd.conv_kind)
			KIND_MEAN: x_d = X_W'(sum_q[cmd.conv_ch]) * X_W'(MEAN_MUL) + X_W'(MEAN_BIAS);
			KIND_MIN:  x_d = X_W'(lo_q[cmd.conv_ch]) * X_W'(PCT_SCALE) + X_W'(MINMAX_BIAS);
			KIND_MAX:  x_d = X_W'(hi_q[cmd.conv_ch]) * X_W'(PCT_SCALE) + X_W'(MINMAX_BIAS);
			default:   x_d = '0;
		endcase
	end

	assign recip = (kind_s1 == KIND_MEAN) ? MEAN_RECIP : MINMAX_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_vld_s1 <= 1'b0;
			conv_vld_s2 <= 1'b0;
		end else begin
			conv_vld_s1 <= cmd.conv_en;
			conv_vld_s2 <= conv_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_d;
		kind_s1 <= cmd.conv_kind;
		ch_s1   <= cmd.conv_ch;
		// stage 2: constant divide as reciprocal multiply
		p_s2    <= PROD_W'(x_s1) * PROD_W'(recip);
		kind_s2 <= kind_s1;
		ch_s2   <= ch_s1;
		if (conv_vld_s2) begin
			res_q[ch_s2][kind_s2] <= p_s2[RECIP_SHIFT +: PCT_W];
		end
		if (cmd.load_out) begin
			out_data_q <= packed_res;
		end
	end

	always_comb begin
		packed_res = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			for (int k = 0; k < 3; k++) begin
				packed_res[(c*3+k)*PCT_W +: PCT_W] = res_q[c][k];
			end
		end
	end

	assign out_data       = out_data_q;
	assign stat.pipe_busy = rd_vld_s1 | conv_vld_s1 | conv_vld_s2;

endmodule

// ----- rtl/three_channel_window_stats_core.sv -----
// Three-channel sliding-window statistics core. A store beat (tuser = 0) writes three 12-bit
// readings into the ring at the write pointer and gives no output. A report beat (tuser = 1)
// reads the 60 most recent ring entries backward, one ring read per cycle, then converts the
// nine mean/min/max values to hundredths of a percent through one shared two-stage multiplier,
// one value per cycle. Entries never written read as zero by way of a fill mark, so no clearing
// pass follows reset. Store beats are taken while a finished result waits on the output.
module three_channel_window_stats_core #(
	parameter int RING_DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// a0_raw[11:0], a1_raw[23:12], a2_raw[35:24], zero pad
	input  logic [tcws_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// func
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// ch0_mean, ch0_min, ch0_max, ch1_mean, ch1_min, ch1_max,
	// ch2_mean, ch2_min, ch2_max, 14 bits each, zero pad
	output logic [tcws_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tcws_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tcws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_func   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tcws_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata)
	);

`ifndef NO_ASSERTIONS
	a_report_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_REPORT) |=> !s_axis_tready)
		else $error("input taken right after a report beat");

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.load_out))
		else $error("output valid rose without a result load");

	a_load_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !stat.pipe_busy)
		else $error("result loaded while conversion still in flight");
`endif

endmodule
